>>> design/assert_macros.svh
// assertion helpers shared by the monitor modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property that must also hold while reset is asserted
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> design/i2cbm_pkg.sv
package i2cbm_pkg;

  // monitor phase
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_IDLE = 2'd1,
    PH_XFER = 2'd2
  } phase_e;

  // reported event codes
  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_RESTART = 2'd1,
    EV_BYTE    = 2'd2,
    EV_STOP    = 2'd3
  } event_e;

  localparam int unsigned BitIdxW = 4;
  localparam logic [BitIdxW-1:0] DataBits = 4'd8;

  // one reported event
  typedef struct packed {
    event_e     kind;
    logic [7:0] byte_value;
    logic       not_acked;
    logic       address_byte;
    logic       record_done;
  } event_t;

endpackage

>>> design/i2cbm_if.sv
// bus sample channel
interface i2cbm_sample_if;
  logic valid;
  logic ready;
  logic clock_line;
  logic data_line;
  modport source (output valid, output clock_line, output data_line, input ready);
  modport sink (input valid, input clock_line, input data_line, output ready);
endinterface

// event report channel
interface i2cbm_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] byte_value;
  logic       not_acked;
  logic       address_byte;
  logic       record_done;
  modport source (output valid, output event_kind, output byte_value, output not_acked,
                  output address_byte, output record_done, input ready);
  modport sink (input valid, input event_kind, input byte_value, input not_acked,
                input address_byte, input record_done, output ready);
endinterface

// configuration write channel
interface i2cbm_cfg_if;
  logic valid;
  logic ready;
  logic monitor_enable;
  modport source (output valid, output monitor_enable, input ready);
  modport sink (input valid, input monitor_enable, output ready);
endinterface

>>> design/i2cbm_core.sv
`include "assert_macros.svh"

module i2cbm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                clock_line_i,
  input  logic                data_line_i,
  input  logic                enable_i,
  output logic                res_valid_o,
  output i2cbm_pkg::event_t   res_o
);

  i2cbm_pkg::phase_e                  phase_q, phase_d;
  logic                               prev_clk_q, prev_dat_q;
  logic [i2cbm_pkg::BitIdxW-1:0]      bit_idx_q, bit_idx_d;
  logic [7:0]                         shift_q, shift_d;
  logic                               first_q, first_d;
  logic                               want;
  logic                               clk_rise;
  logic                               clk_held;

  assign clk_rise = !prev_clk_q && clock_line_i;
  assign clk_held = prev_clk_q && clock_line_i;

  // next state and event decode for one sample
  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    first_d   = first_q;
    want      = 1'b0;
    res_o     = '0;
    unique case (phase_q)
      i2cbm_pkg::PH_IDLE: begin
        if (clock_line_i && !data_line_i) begin
          phase_d    = i2cbm_pkg::PH_XFER;
          bit_idx_d  = '0;
          shift_d    = '0;
          first_d    = 1'b1;
          want       = 1'b1;
          res_o.kind = i2cbm_pkg::EV_START;
        end else if (!clock_line_i || !data_line_i) begin
          phase_d = i2cbm_pkg::PH_WAIT;
        end
      end
      i2cbm_pkg::PH_XFER: begin
        if (clk_rise) begin
          if (bit_idx_q < i2cbm_pkg::DataBits) begin
            shift_d   = {shift_q[6:0], data_line_i};
            bit_idx_d = bit_idx_q + 1'b1;
          end else begin
            // acknowledge bit closes the byte
            bit_idx_d          = '0;
            shift_d            = '0;
            first_d            = 1'b0;
            want               = 1'b1;
            res_o.kind         = i2cbm_pkg::EV_BYTE;
            res_o.byte_value   = shift_q;
            res_o.not_acked    = data_line_i;
            res_o.address_byte = first_q;
            res_o.record_done  = first_q && data_line_i;
            if (first_q && data_line_i) begin
              phase_d = i2cbm_pkg::PH_WAIT;
            end
          end
        end else if (clk_held && (data_line_i != prev_dat_q)) begin
          bit_idx_d = '0;
          shift_d   = '0;
          want      = 1'b1;
          if (!data_line_i) begin
            phase_d    = i2cbm_pkg::PH_XFER;
            first_d    = 1'b1;
            res_o.kind = i2cbm_pkg::EV_RESTART;
          end else begin
            phase_d           = i2cbm_pkg::PH_IDLE;
            first_d           = 1'b0;
            res_o.kind        = i2cbm_pkg::EV_STOP;
            res_o.record_done = 1'b1;
          end
        end
      end
      default: begin
        phase_d = (clock_line_i && data_line_i) ? i2cbm_pkg::PH_IDLE : i2cbm_pkg::PH_WAIT;
      end
    endcase
    // disabled monitor drops the event and waits for an idle bus
    if (want && !enable_i) begin
      phase_d = i2cbm_pkg::PH_WAIT;
    end
  end

  assign res_valid_o = step_i && want && enable_i;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= i2cbm_pkg::PH_WAIT;
      prev_clk_q <= 1'b1;
      prev_dat_q <= 1'b1;
      bit_idx_q  <= '0;
      shift_q    <= '0;
      first_q    <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      prev_clk_q <= clock_line_i;
      prev_dat_q <= data_line_i;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
      first_q    <= first_d;
    end
  end

  `ASSERT_CLK(a_bit_idx_range, clk_i, rst_ni, bit_idx_q <= i2cbm_pkg::DataBits,
              "bit index past acknowledge slot")
  `ASSERT_CLK(a_res_needs_enable, clk_i, rst_ni, !res_valid_o || enable_i,
              "event reported while monitor disabled")
  `ASSERT_CLK(a_phase_legal, clk_i, rst_ni,
              phase_q == i2cbm_pkg::PH_WAIT || phase_q == i2cbm_pkg::PH_IDLE ||
              phase_q == i2cbm_pkg::PH_XFER,
              "monitor phase outside its encoding")

endmodule

>>> design/i2cbm_out_stage.sv
module i2cbm_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                res_valid_i,
  input  i2cbm_pkg::event_t   res_i,
  output logic                full_o,
  i2cbm_event_if.source       event_o
);

  logic                valid_q, valid_d;
  i2cbm_pkg::event_t   data_q;

  // a new load replaces the slot, a taken transfer empties it
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (event_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign full_o             = valid_q;
  assign event_o.valid      = valid_q;
  assign event_o.event_kind = data_q.kind;
  assign event_o.byte_value = data_q.byte_value;
  assign event_o.not_acked  = data_q.not_acked;
  assign event_o.address_byte = data_q.address_byte;
  assign event_o.record_done  = data_q.record_done;

endmodule

>>> design/i2c_bus_monitor_unit.sv
// channel   dir  modport  payload
// sample_i  in   sink     clock_line, data_line
// event_o   out  source   event_kind, byte_value, not_acked, address_byte, record_done
// cfg_i     in   sink     monitor_enable
//
// one sample per cycle while the result register can be loaded; a sample's event passes
// through the input register, then decode into the result register
// the result register frees in the cycle it is taken, so a held sink stalls the decode,
// the input register and then the sample channel
// reset is asynchronous; the monitor comes up enabled, waiting for an idle bus
// configuration writes take effect in the next cycle and are always ready
`include "assert_macros.svh"

module i2c_bus_monitor_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  i2cbm_sample_if.sink    sample_i,
  i2cbm_event_if.source   event_o,
  i2cbm_cfg_if.sink       cfg_i
);

  logic                smp_valid_q;
  logic                smp_clk_q;
  logic                smp_dat_q;
  logic                enable_q;
  logic                advance;
  logic                out_full;
  logic                res_valid;
  i2cbm_pkg::event_t   res;

  // decode runs once the result slot can take its outcome
  assign advance        = smp_valid_q && (!out_full || event_o.ready);
  assign sample_i.ready = !smp_valid_q || advance;
  assign cfg_i.ready    = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      smp_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      smp_clk_q <= sample_i.clock_line;
      smp_dat_q <= sample_i.data_line;
    end
  end

  // enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_i.valid) begin
      enable_q <= cfg_i.monitor_enable;
    end
  end

  i2cbm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .clock_line_i (smp_clk_q),
    .data_line_i  (smp_dat_q),
    .enable_i     (enable_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  i2cbm_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (out_full),
    .event_o     (event_o)
  );

  `ASSERT_CLK(a_nonbyte_zero, clk_i, rst_ni,
              !event_o.valid || event_o.event_kind == i2cbm_pkg::EV_BYTE ||
              (event_o.byte_value == 8'd0 && !event_o.not_acked && !event_o.address_byte),
              "non-byte event carries byte fields")
  `ASSERT_CLK(a_done_cause, clk_i, rst_ni,
              !(event_o.valid && event_o.record_done) ||
              event_o.event_kind == i2cbm_pkg::EV_STOP ||
              (event_o.address_byte && event_o.not_acked),
              "record end without stop or address nack")
  `ASSERT_CLK(a_no_advance_blocked, clk_i, rst_ni,
              !(advance && out_full && !event_o.ready),
              "decode overwrote an untaken result")

endmodule
